@@ src/five_point_derivative_stream_macros.svh @@
// Assertion helpers for the checker file.
`ifndef FIVE_POINT_DERIVATIVE_STREAM_MACROS_SVH
`define FIVE_POINT_DERIVATIVE_STREAM_MACROS_SVH

// Clocked check, muted while reset is held
`define FPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also applies during reset
`define FPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/fpd_pkg.sv @@
package fpd_pkg;

  // Fixed field widths
  localparam int SAMPLE_WIDTH   = 32;
  localparam int MAX_RUN_LENGTH = 65536;
  localparam int RECIP_W        = 32;
  localparam int FRAC_W         = 16;
  localparam int IDX_W          = 16;
  localparam int HIST_DEPTH     = 4;

  // Stencil sum needs five bits of headroom: |8*(a-b) + (c-d)| < 9 * 2^W
  localparam int SUM_W = SAMPLE_WIDTH + 5;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_TWO    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_TWELVE = 1'd1;

  localparam logic [RECIP_W-1:0] RECIP_TWO_RST    = 32'd65536;
  localparam logic [RECIP_W-1:0] RECIP_TWELVE_RST = 32'd10923;

  // Which reciprocal a result is scaled by
  typedef enum logic {
    COEF_TWO,
    COEF_TWELVE
  } coef_sel_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] derivative;
    logic [IDX_W-1:0]               point_index;
    logic                           end_of_run;
    logic                           short_run;
  } out_item_t;

  // One pending result: unscaled difference plus its tags
  typedef struct packed {
    logic signed [SUM_W-1:0] num;
    coef_sel_t               sel;
    logic [IDX_W-1:0]        point_index;
    logic                    end_of_run;
    logic                    short_run;
  } job_t;

endpackage

@@ src/five_point_derivative_stream.sv @@
// Streaming first derivative of a sampled function, signed Q16.16.
// Input channel (in_valid / in_stall / in_item): one sample per item; the
// item with last_sample set closes the run. Result channel (out_valid /
// out_stall / out_item): derivatives in point order with their point index.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0: 1/(2h), 1: 1/(12h)); write only while the block is idle.
// Throughput: one sample per cycle while the input is not stalled. The
// closing sample of a run of two or more points holds the input while its
// flushed results (one for a run of two samples, two otherwise) issue one per
// cycle into the shared scaler as it accepts them.
// Path: a result passes from the item that issues it through the issue
// register, the partial-product register and the output register. In
// samples, results trail the input by two points.
// Stall: a stalled result holds in the output register; the scaler stages
// and issue register keep filling, and the input stalls once the issue
// register cannot drain.
// Reset (synchronous, rst_n low): reciprocals return to 1.0 and 1/6,
// the point count clears, all pipeline stages empty.
module five_point_derivative_stream #(
  parameter int MAX_RUN_LENGTH = fpd_pkg::MAX_RUN_LENGTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fpd_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fpd_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [fpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fpd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int W     = fpd_pkg::SAMPLE_WIDTH;
  localparam int SUM_W = fpd_pkg::SUM_W;
  localparam int IDX_W = fpd_pkg::IDX_W;
  localparam int DEPTH = fpd_pkg::HIST_DEPTH;
  localparam int CNT_W = (MAX_RUN_LENGTH > 1) ? $clog2(MAX_RUN_LENGTH) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RUN_LENGTH - 1);

  // Configuration registers
  logic [fpd_pkg::RECIP_W-1:0] recip_two_r, recip_two_nxt;
  logic [fpd_pkg::RECIP_W-1:0] recip_twelve_r, recip_twelve_nxt;

  // Run state and issue stage
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        pend_r, pend_nxt;
  fpd_pkg::job_t     q1_r, q1_nxt, q2_r, q2_nxt;
  logic              a_v_r, a_v_nxt;
  fpd_pkg::job_t     a_job_r, a_job_nxt;

  logic                    busy, rdy_a, accept, shift_en, has_job, is_last;
  logic                    job_ready;
  logic [31:0]             k32;
  logic signed [W-1:0]     hist [DEPTH];
  logic signed [SUM_W-1:0] xx, h0x, h1x, h2x, h3x, stencil, cen_lag, cen_end;
  fpd_pkg::job_t           lag_job, job0, job1, job2;
  logic [1:0]              job_cnt;

  // Configuration writes
  always_comb begin
    recip_two_nxt    = recip_two_r;
    recip_twelve_nxt = recip_twelve_r;
    if (cfg_we) begin
      case (cfg_index)
        fpd_pkg::REG_RECIP_TWO:    recip_two_nxt    = cfg_wdata;
        fpd_pkg::REG_RECIP_TWELVE: recip_twelve_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake
  assign busy     = (pend_r != 2'd0);
  assign rdy_a    = !a_v_r || job_ready;
  assign in_stall = busy || !rdy_a;
  assign accept   = in_valid && !in_stall;
  assign is_last  = in_item.last_sample;
  assign shift_en = accept && !is_last;

  // Delay line: four chained cells, newest in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_hist
    if (i == 0) begin : g_head
      fpd_cell #(.DATA_W(W)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (in_item.sample),
        .d_out    (hist[i])
      );
    end else begin : g_tail
      fpd_cell #(.DATA_W(W)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (hist[i-1]),
        .d_out    (hist[i])
      );
    end
  end

  // Differences over the delay line and the incoming sample
  always_comb begin
    k32     = 32'(cnt_r);
    xx      = SUM_W'(in_item.sample);
    h0x     = SUM_W'(hist[0]);
    h1x     = SUM_W'(hist[1]);
    h2x     = SUM_W'(hist[2]);
    h3x     = SUM_W'(hist[3]);
    stencil = ((h0x - h2x) <<< 3) + (h3x - xx);
    cen_lag = h0x - h2x;
    cen_end = xx - h1x;
  end

  // Result for the point two behind the incoming sample
  always_comb begin
    lag_job.sel         = fpd_pkg::COEF_TWELVE;
    lag_job.num         = stencil;
    lag_job.point_index = IDX_W'(k32 - 32'd2);
    lag_job.end_of_run  = 1'b0;
    lag_job.short_run   = 1'b0;
    if (k32 == 32'd2) begin
      lag_job.num = '0;
    end else if (k32 == 32'd3) begin
      lag_job.num = cen_lag;
      lag_job.sel = fpd_pkg::COEF_TWO;
    end
  end

  // Results issued by this item: first one now, the rest queued
  always_comb begin
    job0    = lag_job;
    job1    = '{num: '0, sel: fpd_pkg::COEF_TWO, point_index: '0,
                end_of_run: 1'b0, short_run: 1'b0};
    job2    = job1;
    job_cnt = 2'd0;
    has_job = (k32 >= 32'd2);
    if (is_last) begin
      has_job = 1'b1;
      if (k32 == 32'd0) begin
        // lone sample
        job0.num        = '0;
        job0.point_index = '0;
        job0.end_of_run = 1'b1;
      end else if (k32 == 32'd1) begin
        // two-sample run: both ends are zero and flagged
        job0.num         = '0;
        job0.point_index = '0;
        job0.short_run   = 1'b1;
        job1.point_index = IDX_W'(1);
        job1.end_of_run  = 1'b1;
        job1.short_run   = 1'b1;
        job_cnt          = 2'd1;
      end else begin
        job1.num         = cen_end;
        job1.point_index = IDX_W'(k32 - 32'd1);
        job2.point_index = IDX_W'(k32);
        job2.end_of_run  = 1'b1;
        job_cnt          = 2'd2;
      end
    end
  end

  // Issue register, flush queue and point count
  always_comb begin
    a_v_nxt   = a_v_r;
    a_job_nxt = a_job_r;
    pend_nxt  = pend_r;
    q1_nxt    = q1_r;
    q2_nxt    = q2_r;
    cnt_nxt   = cnt_r;
    if (rdy_a) begin
      a_v_nxt = 1'b0;
      if (accept && has_job) begin
        a_v_nxt   = 1'b1;
        a_job_nxt = job0;
      end else if (busy) begin
        a_v_nxt   = 1'b1;
        a_job_nxt = q1_r;
        q1_nxt    = q2_r;
        pend_nxt  = pend_r - 2'd1;
      end
    end
    if (accept) begin
      if (is_last) begin
        cnt_nxt  = '0;
        pend_nxt = job_cnt;
        q1_nxt   = job1;
        q2_nxt   = job2;
      end else if (cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_two_r    <= fpd_pkg::RECIP_TWO_RST;
      recip_twelve_r <= fpd_pkg::RECIP_TWELVE_RST;
      cnt_r          <= '0;
      pend_r         <= 2'd0;
      a_v_r          <= 1'b0;
    end else begin
      recip_two_r    <= recip_two_nxt;
      recip_twelve_r <= recip_twelve_nxt;
      cnt_r          <= cnt_nxt;
      pend_r         <= pend_nxt;
      a_v_r          <= a_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_job_r <= a_job_nxt;
    q1_r    <= q1_nxt;
    q2_r    <= q2_nxt;
  end

  // Shared multiply and saturate pipeline
  fpd_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (a_v_r),
    .job          (a_job_r),
    .job_ready    (job_ready),
    .recip_two    (recip_two_r),
    .recip_twelve (recip_twelve_r),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .out_stall    (out_stall)
  );

endmodule

@@ src/fpd_cell.sv @@
// One tap of the sample delay line; passes its value to the next tap on shift.
module fpd_cell #(
  parameter int DATA_W = fpd_pkg::SAMPLE_WIDTH
) (
  input  logic                     clk,
  input  logic                     shift_en,
  input  logic signed [DATA_W-1:0] d_in,
  output logic signed [DATA_W-1:0] d_out
);

  logic signed [DATA_W-1:0] d_r;
  logic signed [DATA_W-1:0] d_nxt;

  always_comb begin
    d_nxt = d_r;
    if (shift_en) begin
      d_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

@@ src/fpd_scale.sv @@
// Two-stage scaler: split multiply by the selected reciprocal, then
// recombine, floor-shift by the fraction width and saturate.
module fpd_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  fpd_pkg::job_t                job,
  output logic                         job_ready,
  input  logic [fpd_pkg::RECIP_W-1:0]  recip_two,
  input  logic [fpd_pkg::RECIP_W-1:0]  recip_twelve,
  output logic                         out_valid,
  output fpd_pkg::out_item_t           out_item,
  input  logic                         out_stall
);

  localparam int W      = fpd_pkg::SAMPLE_WIDTH;
  localparam int SUM_W  = fpd_pkg::SUM_W;
  localparam int RW     = fpd_pkg::RECIP_W;
  localparam int LO_W   = SUM_W / 2;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int PLO_W  = LO_W + RW;
  localparam int PHI_W  = HI_W + RW + 1;
  localparam int PROD_W = SUM_W + RW + 1;

  localparam logic signed [PROD_W-1:0] SAT_MAX = {{(PROD_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_MIN = {{(PROD_W-W+1){1'b1}}, {(W-1){1'b0}}};

  // Stage B: partial products
  logic                          b_v_r, b_v_nxt;
  logic [PLO_W-1:0]              p_lo_r, p_lo_nxt;
  logic signed [PHI_W-1:0]       p_hi_r, p_hi_nxt;
  logic [fpd_pkg::IDX_W-1:0]     b_idx_r, b_idx_nxt;
  logic                          b_end_r, b_end_nxt;
  logic                          b_short_r, b_short_nxt;

  // Stage C: output register
  logic                          o_v_r, o_v_nxt;
  fpd_pkg::out_item_t            o_item_r, o_item_nxt;

  logic                          rdy_b, rdy_c;
  logic [RW-1:0]                 recip;
  logic [LO_W-1:0]               lo_part;
  logic signed [HI_W-1:0]        hi_part;
  logic signed [PROD_W-1:0]      hi_ext, lo_ext, full, shifted;
  logic signed [W-1:0]           sat_val;

  // Stage readiness, back to front
  assign rdy_c     = !o_v_r || !out_stall;
  assign rdy_b     = !b_v_r || rdy_c;
  assign job_ready = rdy_b;

  // Stage B datapath
  always_comb begin
    recip   = (job.sel == fpd_pkg::COEF_TWO) ? recip_two : recip_twelve;
    lo_part = job.num[LO_W-1:0];
    hi_part = job.num[SUM_W-1:LO_W];
  end

  always_comb begin
    b_v_nxt     = b_v_r;
    p_lo_nxt    = p_lo_r;
    p_hi_nxt    = p_hi_r;
    b_idx_nxt   = b_idx_r;
    b_end_nxt   = b_end_r;
    b_short_nxt = b_short_r;
    if (rdy_b) begin
      b_v_nxt = job_valid;
      if (job_valid) begin
        p_lo_nxt    = lo_part * recip;
        p_hi_nxt    = hi_part * $signed({1'b0, recip});
        b_idx_nxt   = job.point_index;
        b_end_nxt   = job.end_of_run;
        b_short_nxt = job.short_run;
      end
    end
  end

  // Stage C datapath: recombine, floor shift, saturate
  always_comb begin
    hi_ext  = PROD_W'(p_hi_r);
    lo_ext  = $signed(PROD_W'(p_lo_r));
    full    = (hi_ext <<< LO_W) + lo_ext;
    shifted = full >>> fpd_pkg::FRAC_W;
    if (shifted > SAT_MAX) begin
      sat_val = SAT_MAX[W-1:0];
    end else if (shifted < SAT_MIN) begin
      sat_val = SAT_MIN[W-1:0];
    end else begin
      sat_val = shifted[W-1:0];
    end
  end

  always_comb begin
    o_v_nxt    = o_v_r;
    o_item_nxt = o_item_r;
    if (rdy_c) begin
      o_v_nxt = b_v_r;
      if (b_v_r) begin
        o_item_nxt.derivative  = sat_val;
        o_item_nxt.point_index = b_idx_r;
        o_item_nxt.end_of_run  = b_end_r;
        o_item_nxt.short_run   = b_short_r;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      b_v_r <= b_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p_lo_r    <= p_lo_nxt;
    p_hi_r    <= p_hi_nxt;
    b_idx_r   <= b_idx_nxt;
    b_end_r   <= b_end_nxt;
    b_short_r <= b_short_nxt;
    o_item_r  <= o_item_nxt;
  end

  assign out_valid = o_v_r;
  assign out_item  = o_item_r;

endmodule

@@ src/fpd_checker.sv @@
`include "five_point_derivative_stream_macros.svh"

// Port-level checks on the derivative stream.
module fpd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input fpd_pkg::in_item_t              in_item,
  input logic                           out_valid,
  input logic                           out_stall,
  input fpd_pkg::out_item_t             out_item
);

  // A stalled sample stays put
  `FPD_ASSERT(a_in_hold,
    (in_valid && in_stall |=> in_valid && $stable(in_item)),
    "stalled sample changed")

  // A stalled result stays put
  `FPD_ASSERT(a_out_hold,
    (out_valid && out_stall |=> out_valid && $stable(out_item)),
    "stalled result changed")

  // Reset empties the output
  `FPD_ASSERT_ALWAYS(a_rst_empty, (!rst_n |=> !out_valid), "result valid after reset")

  // The last point of a run always has zero slope
  `FPD_ASSERT(a_end_zero,
    (out_valid && out_item.end_of_run |-> out_item.derivative == '0),
    "nonzero end point")

  // Two-sample runs give only points 0 and 1, both zero
  `FPD_ASSERT(a_short_run,
    (out_valid && out_item.short_run |-> out_item.derivative == '0 &&
     out_item.point_index[fpd_pkg::IDX_W-1:1] == '0),
    "bad short-run result")

endmodule

bind five_point_derivative_stream fpd_checker u_fpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ tb/sv/five_point_derivative_stream_tb.sv @@
`timescale 1ns / 100ps

module five_point_derivative_stream_tb;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 50;
  localparam logic [31:0] S_MAX = 32'h7fffffff;
  localparam logic [31:0] S_MIN = 32'h80000000;
  localparam longint DERIV_MAX = 64'sd2147483647;
  localparam longint DERIV_MIN = -64'sd2147483648;

  // Predicts derivative items from accepted samples and checks the output stream
  class deriv_scoreboard;
    logic [31:0] recip_two;
    logic [31:0] recip_twelve;
    longint      hist [4];      // entry 0 is the newest sample
    int unsigned seen;
    fpd_pkg::out_item_t expected_q [$];
    int unsigned mismatches;

    function new();
      recip_two    = fpd_pkg::RECIP_TWO_RST;
      recip_twelve = fpd_pkg::RECIP_TWELVE_RST;
      foreach (hist[i]) hist[i] = 0;
      seen       = 0;
      mismatches = 0;
    endfunction

    // floor(diff * recip / 2^16), clipped to the signed 32-bit range
    function logic signed [31:0] scale_q16(longint diff, logic [31:0] recip);
      logic signed [79:0] wide_diff;
      logic signed [79:0] wide_recip;
      logic signed [79:0] shifted;
      wide_diff  = diff;
      wide_recip = {48'd0, recip};
      shifted    = (wide_diff * wide_recip) >>> 16;
      if (shifted > DERIV_MAX) return DERIV_MAX[31:0];
      if (shifted < DERIV_MIN) return DERIV_MIN[31:0];
      return shifted[31:0];
    endfunction

    // Derivative at point k-2 once sample k (value x) arrives
    function logic signed [31:0] lagged_deriv(int unsigned k, longint x);
      if (k == 2) return '0;
      if (k == 3) return scale_q16(hist[0] - hist[2], recip_two);
      return scale_q16(hist[3] - 8 * hist[2] + 8 * hist[0] - x, recip_twelve);
    endfunction

    function void expect_point(logic signed [31:0] d, int unsigned idx, bit eor, bit shrt);
      fpd_pkg::out_item_t e;
      e.derivative  = d;
      e.point_index = 16'(idx);
      e.end_of_run  = eor;
      e.short_run   = shrt;
      expected_q.push_back(e);
    endfunction

    function void note_sample(fpd_pkg::in_item_t it);
      longint      x;
      int unsigned k;
      x = $signed(it.sample);
      k = seen;
      if (!it.last_sample) begin
        if (k >= 2) expect_point(lagged_deriv(k, x), k - 2, 1'b0, 1'b0);
        hist[3] = hist[2];
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = x;
        // index saturates on overlong runs
        if (seen < fpd_pkg::MAX_RUN_LENGTH - 1) seen++;
      end else begin
        if (k == 0) begin
          expect_point('0, 0, 1'b1, 1'b0);
        end else if (k == 1) begin
          expect_point('0, 0, 1'b0, 1'b1);
          expect_point('0, 1, 1'b1, 1'b1);
        end else begin
          expect_point(lagged_deriv(k, x), k - 2, 1'b0, 1'b0);
          expect_point(scale_q16(x - hist[1], recip_two), k - 1, 1'b0, 1'b0);
          expect_point('0, k, 1'b1, 1'b0);
        end
        foreach (hist[i]) hist[i] = 0;
        seen = 0;
      end
    endfunction

    function void complain(string what, longint exp_val, longint act_val);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_val, act_val);
    endfunction

    function void check_result(fpd_pkg::out_item_t got);
      fpd_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected item, expected none actual derivative %0d index %0d",
                   $time, got.derivative, got.point_index);
        return;
      end
      e = expected_q.pop_front();
      if (got.derivative !== e.derivative)
        complain("derivative", e.derivative, got.derivative);
      if (got.point_index !== e.point_index)
        complain("point_index", e.point_index, got.point_index);
      if (got.end_of_run !== e.end_of_run)
        complain("end_of_run", e.end_of_run, got.end_of_run);
      if (got.short_run !== e.short_run)
        complain("short_run", e.short_run, got.short_run);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  fpd_pkg::in_item_t  in_item;
  logic        out_valid;
  logic        out_stall = 1'b0;
  fpd_pkg::out_item_t out_item;
  logic        cfg_we;
  logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fpd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bit          idle_on = 1'b1;
  int unsigned cycle_cnt = 0;
  deriv_scoreboard sb = new();

  five_point_derivative_stream i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output monitor and random back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    out_stall <= idle_on && ($urandom_range(99) < 27);
  end

  // Present one sample and hold it until accepted
  task automatic push_sample(logic [31:0] value, bit last);
    fpd_pkg::in_item_t it;
    it.sample      = value;
    it.last_sample = last;
    while (idle_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(it);
  endtask

  function automatic logic [31:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return $urandom();
    if (r < 80) return $urandom_range(8191) - 32'd4096;
    case ($urandom_range(4))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return 32'h0;
      3:       return 32'hffffffff;
      default: return 32'h00010000;
    endcase
  endfunction

  task automatic send_run(int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_sample(pick_sample(), i == len - 1);
  endtask

  // Whole runs of random length until the sample budget is spent
  task automatic send_random_runs(int unsigned budget);
    int unsigned len;
    int unsigned r;
    while (budget > 0) begin
      r = $urandom_range(99);
      if (r < 10)      len = $urandom_range(2, 1);
      else if (r < 70) len = $urandom_range(12, 3);
      else             len = $urandom_range(40, 13);
      if (len > budget) len = budget;
      send_run(len);
      budget -= len;
    end
  endtask

  // Hold off input until every expected item is out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_recips(logic [31:0] two, logic [31:0] twelve);
    cfg_we    <= 1'b1;
    cfg_index <= fpd_pkg::REG_RECIP_TWO;
    cfg_wdata <= two;
    @(posedge clk);
    cfg_index <= fpd_pkg::REG_RECIP_TWELVE;
    cfg_wdata <= twelve;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.recip_two    = two;
    sb.recip_twelve = twelve;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= fpd_pkg::REG_RECIP_TWO;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed runs with reset reciprocals
    // one-sample run
    push_sample(S_MAX, 1'b1);
    // two-sample run: zero derivatives, short flag
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b1);
    // three and four samples: central differences only
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b1);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(32'h0, 1'b1);
    // alternating extremes give the largest stencil sums
    for (int i = 0; i < 6; i++) push_sample((i % 2) ? S_MIN : S_MAX, i == 5);
    // small values around zero and one
    push_sample(32'hffffffff, 1'b0);
    push_sample(32'h0, 1'b0);
    push_sample(32'h1, 1'b0);
    push_sample(32'h00010000, 1'b0);
    push_sample(32'hffff0000, 1'b0);
    push_sample(32'h00030000, 1'b0);
    push_sample(32'hfffe8000, 1'b1);

    // zero scale: every derivative collapses to zero
    wait_drained();
    write_recips(32'h0, 32'h0);
    send_random_runs(80);

    // full scale: heavy saturation
    wait_drained();
    write_recips(32'hffffffff, 32'hffffffff);
    send_random_runs(80);

    // random scale, no idling on either side
    wait_drained();
    idle_on <= 1'b0;
    write_recips($urandom(), $urandom());
    send_random_runs(100);
    idle_on <= 1'b1;

    // one run of 24 samples, then more random runs
    wait_drained();
    write_recips($urandom_range(32'h00100000, 1), $urandom_range(32'h00040000, 1));
    send_run(24);
    send_random_runs(70);

    // back to nominal step
    wait_drained();
    write_recips(fpd_pkg::RECIP_TWO_RST, fpd_pkg::RECIP_TWELVE_RST);
    send_random_runs(90);

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ five_point_derivative_stream.f @@
+incdir+src
src/fpd_pkg.sv
src/fpd_cell.sv
src/fpd_scale.sv
src/five_point_derivative_stream.sv
src/fpd_checker.sv
tb/sv/five_point_derivative_stream_tb.sv
